// ===== rtl/core/cpc_pkg.sv =====
// Shared types, constants and tables for the cartesian/polar converter.
`timescale 1ns / 1ps
package cpc_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TAB_LEN = 24;
  localparam int CORDIC_N = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int SQRT_BITS = 17;
  localparam int CORE_STAGES = (CORDIC_N > SQRT_BITS) ? CORDIC_N : SQRT_BITS;
  localparam int TOTAL_STAGES = CORE_STAGES + 4;

  localparam int XY_W = 52;
  localparam int Z_W = 34;
  localparam int REM_W = 34;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

  // Configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  // Region codes
  localparam logic [3:0] REGION_ORIGIN = 4'd0;
  localparam logic [3:0] REGION_Q1     = 4'd1;
  localparam logic [3:0] REGION_Q2     = 4'd2;
  localparam logic [3:0] REGION_Q3     = 4'd3;
  localparam logic [3:0] REGION_Q4     = 4'd4;
  localparam logic [3:0] REGION_POS_X  = 4'd5;
  localparam logic [3:0] REGION_POS_Y  = 4'd6;
  localparam logic [3:0] REGION_NEG_X  = 4'd7;
  localparam logic [3:0] REGION_NEG_Y  = 4'd8;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    v = '0;
    if (int'(idx) < TAB_LEN) begin
      v = ATAN_TAB[idx];
    end
    return v;
  endfunction

  // Data that moves through the core stages
  typedef struct packed {
    logic                    kind;
    logic [3:0]              region;
    logic [1:0]              quad;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic [REM_W-1:0]        rem;
    logic [SQRT_BITS-1:0]    root;
  } stage_t;

endpackage

// ===== rtl/core/cpc_if.sv =====
// Request and response channel interfaces for the converter.
`timescale 1ns / 1ps
interface cpc_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic [15:0] radius;
  logic [15:0] angle_in;

  modport source (output valid, kind, point_x, point_y, radius, angle_in, input ready);
  modport sink (input valid, kind, point_x, point_y, radius, angle_in, output ready);
endinterface

interface cpc_rsp_if;
  logic        valid;
  logic        ready;
  logic [17:0] signed_distance;
  logic [15:0] angle_out;
  logic [3:0]  region;
  logic [16:0] rect_x;
  logic [16:0] rect_y;

  modport source (output valid, signed_distance, angle_out, region, rect_x, rect_y,
                  input ready);
  modport sink (input valid, signed_distance, angle_out, region, rect_x, rect_y,
                output ready);
endinterface

// ===== rtl/core/cpc_front.sv =====
// Front stages: offsets, region, squares, gain product and core init.
`timescale 1ns / 1ps
module cpc_front (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  logic                 kind,
  input  logic signed [15:0]   point_x,
  input  logic signed [15:0]   point_y,
  input  logic [15:0]          radius,
  input  logic [15:0]          angle_in,
  input  logic signed [15:0]   origin_x,
  input  logic signed [15:0]   origin_y,
  output cpc_pkg::stage_t      init
);

  // stage A
  logic               a_kind;
  logic signed [16:0] a_dx;
  logic signed [16:0] a_dy;
  logic [15:0]        a_r;
  logic [15:0]        a_ang;

  // stage B
  logic               b_kind;
  logic [3:0]         b_region;
  logic [1:0]         b_quad;
  logic [15:0]        b_ax;
  logic [15:0]        b_ay;
  logic [31:0]        b_sqx;
  logic [31:0]        b_sqy;
  logic [47:0]        b_prod;
  logic signed [13:0] b_res;

  logic [15:0]        ax;
  logic [15:0]        ay;
  logic [16:0]        ang_sum;
  logic [3:0]         region;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_kind <= kind;
      a_dx   <= 17'(point_x) - 17'(origin_x);
      a_dy   <= 17'(point_y) - 17'(origin_y);
      a_r    <= radius;
      a_ang  <= angle_in;
    end
  end

  always_comb begin
    logic [16:0] nx;
    logic [16:0] ny;
    nx = -a_dx;
    ny = -a_dy;
    ax = a_dx[16] ? nx[15:0] : a_dx[15:0];
    ay = a_dy[16] ? ny[15:0] : a_dy[15:0];
    ang_sum = {1'b0, a_ang} + 17'h2000;
    priority if (a_dx == '0 && a_dy == '0) begin
      region = cpc_pkg::REGION_ORIGIN;
    end else if (a_dy == '0) begin
      region = a_dx[16] ? cpc_pkg::REGION_NEG_X : cpc_pkg::REGION_POS_X;
    end else if (a_dx == '0) begin
      region = a_dy[16] ? cpc_pkg::REGION_NEG_Y : cpc_pkg::REGION_POS_Y;
    end else if (!a_dx[16] && !a_dy[16]) begin
      region = cpc_pkg::REGION_Q1;
    end else if (a_dx[16] && !a_dy[16]) begin
      region = cpc_pkg::REGION_Q2;
    end else if (a_dx[16]) begin
      region = cpc_pkg::REGION_Q3;
    end else begin
      region = cpc_pkg::REGION_Q4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      b_kind   <= a_kind;
      b_region <= region;
      b_quad   <= ang_sum[15:14];
      b_ax     <= ax;
      b_ay     <= ay;
      b_sqx    <= ax * ax;
      b_sqy    <= ay * ay;
      b_prod   <= 48'(a_r) * 48'(cpc_pkg::GAIN_Q32);
      b_res    <= {~ang_sum[13], ang_sum[12:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      init.kind   <= b_kind;
      init.region <= b_kind ? cpc_pkg::REGION_ORIGIN : b_region;
      init.quad   <= b_quad;
      init.rem    <= cpc_pkg::REM_W'(b_sqx) + cpc_pkg::REM_W'(b_sqy);
      init.root   <= '0;
      if (b_kind) begin
        init.x <= cpc_pkg::XY_W'(b_prod);
        init.y <= '0;
        init.z <= {{(cpc_pkg::Z_W-30){b_res[13]}}, b_res, 16'd0};
      end else begin
        init.x <= cpc_pkg::XY_W'({b_ax, 16'd0});
        init.y <= cpc_pkg::XY_W'({b_ay, 16'd0});
        init.z <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/cpc_stage.sv =====
// One core stage: a CORDIC micro-rotation (if idx < CORDIC_N) and one square-root bit (if idx < SQRT_BITS).
`timescale 1ns / 1ps
module cpc_stage (
  input  logic            clk,
  input  logic [4:0]      idx,
  input  logic            en,
  input  cpc_pkg::stage_t d,
  output cpc_pkg::stage_t q
);

  cpc_pkg::stage_t nxt;

  always_comb begin
    logic signed [cpc_pkg::XY_W-1:0] sx;
    logic signed [cpc_pkg::XY_W-1:0] sy;
    logic signed [cpc_pkg::Z_W-1:0]  at;
    logic                            plus;
    logic [4:0]                      b;
    logic [35:0]                     trial;
    nxt   = d;
    sx    = d.x >>> idx;
    sy    = d.y >>> idx;
    at    = cpc_pkg::Z_W'(cpc_pkg::atan_entry(idx));
    // vectoring steers by y, rotation by z
    plus  = d.kind ? !d.z[cpc_pkg::Z_W-1] : d.y[cpc_pkg::XY_W-1];
    b     = 5'(cpc_pkg::SQRT_BITS - 1) - idx;
    trial = (36'(d.root) << (6'(b) + 6'd1)) | (36'd1 << (6'(b) << 1));
    if (int'(idx) < cpc_pkg::CORDIC_N) begin
      if (plus) begin
        nxt.x = d.x - sy;
        nxt.y = d.y + sx;
        nxt.z = d.z - at;
      end else begin
        nxt.x = d.x + sy;
        nxt.y = d.y - sx;
        nxt.z = d.z + at;
      end
    end
    if (int'(idx) < cpc_pkg::SQRT_BITS) begin
      if (36'(d.rem) >= trial) begin
        nxt.rem  = d.rem - cpc_pkg::REM_W'(trial);
        nxt.root = d.root | (cpc_pkg::SQRT_BITS'(1) << b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

// ===== rtl/core/cpc_finish.sv =====
// Output stage: angle mapping, distance rounding, quadrant fold and rounding.
`timescale 1ns / 1ps
module cpc_finish (
  input  logic               clk,
  input  logic               en,
  input  cpc_pkg::stage_t    d,
  output logic [17:0]        signed_distance,
  output logic [15:0]        angle_out,
  output logic [3:0]         region,
  output logic [16:0]        rect_x,
  output logic [16:0]        rect_y
);

  logic [17:0] dist_n;
  logic [15:0] ang_n;
  logic [16:0] rx_n;
  logic [16:0] ry_n;

  function automatic logic [16:0] round_q32(input logic signed [cpc_pkg::XY_W-1:0] v);
    logic signed [cpc_pkg::XY_W-1:0] s;
    logic signed [cpc_pkg::XY_W-33:0] r;
    logic [16:0] o;
    s = v + (cpc_pkg::XY_W'(1) << 31);
    r = s[cpc_pkg::XY_W-1:32];
    if (r > 65535) begin
      o = 17'd65535;
    end else if (r < -65535) begin
      o = -17'sd65535;
    end else begin
      o = r[16:0];
    end
    return o;
  endfunction

  always_comb begin
    logic signed [cpc_pkg::Z_W-1:0] zr;
    logic [14:0]                    t;
    logic [17:0]                    mag;
    logic signed [cpc_pkg::XY_W-1:0] fx;
    logic signed [cpc_pkg::XY_W-1:0] fy;
    zr  = (d.z + cpc_pkg::Z_W'(32768)) >>> 16;
    if (zr[cpc_pkg::Z_W-1]) begin
      t = '0;
    end else if (zr > 16384) begin
      t = 15'd16384;
    end else begin
      t = zr[14:0];
    end
    mag = 18'(d.root) + 18'(36'(d.rem) > 36'(d.root));
    unique case (d.region)
      cpc_pkg::REGION_Q1:    ang_n = 16'(t);
      cpc_pkg::REGION_Q2:    ang_n = 16'd32768 - 16'(t);
      cpc_pkg::REGION_Q3:    ang_n = 16'd32768 + 16'(t);
      cpc_pkg::REGION_Q4:    ang_n = 16'd0 - 16'(t);
      cpc_pkg::REGION_POS_Y: ang_n = 16'd16384;
      cpc_pkg::REGION_NEG_X: ang_n = 16'd32768;
      cpc_pkg::REGION_NEG_Y: ang_n = 16'd49152;
      default:               ang_n = '0;
    endcase
    if (d.region == cpc_pkg::REGION_Q2 || d.region == cpc_pkg::REGION_Q4) begin
      dist_n = -mag;
    end else begin
      dist_n = mag;
    end
    unique case (d.quad)
      2'd0: begin fx = d.x;  fy = d.y;  end
      2'd1: begin fx = -d.y; fy = d.x;  end
      2'd2: begin fx = -d.x; fy = -d.y; end
      default: begin fx = d.y; fy = -d.x; end
    endcase
    rx_n = round_q32(fx);
    ry_n = round_q32(fy);
    if (d.kind) begin
      dist_n = '0;
      ang_n  = '0;
    end else begin
      rx_n = '0;
      ry_n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      signed_distance <= dist_n;
      angle_out       <= ang_n;
      region          <= d.region;
      rect_x          <= rx_n;
      rect_y          <= ry_n;
    end
  end

endmodule

// ===== rtl/core/cartesian_polar_converter_unit.sv =====
// Top level of the pipelined CORDIC cartesian/polar converter.
`timescale 1ns / 1ps
// Each request is a vectoring request (kind 0: point minus origin gives a
// signed rounded distance, an angle in binary units of 2pi/65536 and a region
// code) or a rotation request (kind 1: radius and angle give rounded x and y).
// The block is a fully pipelined datapath: three front stages (offset,
// squares and gain product, core init), one core stage per CORDIC iteration
// or square-root bit, whichever count is larger (17 at the default of 16
// iterations), and one output register. One request is taken every cycle
// unless the response channel stalls; each stage carries its own valid bit
// and a stage advances whenever the stage after it is empty or advancing,
// so bubbles close up during a downstream stall and nothing is lost or
// repeated. Origin registers are written through cfg_we/cfg_index/cfg_data
// and take effect for requests accepted afterwards.
module cartesian_polar_converter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  cpc_req_if.sink     req,
  cpc_rsp_if.source   rsp
);

  localparam int K   = cpc_pkg::CORE_STAGES;
  localparam int TOT = cpc_pkg::TOTAL_STAGES;

  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [TOT-1:0]     vld;
  logic [TOT-1:0]     en;
  cpc_pkg::stage_t    data [K+1];

  // Origin registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cpc_pkg::CFG_ORIGIN_X: origin_x <= cfg_data;
        cpc_pkg::CFG_ORIGIN_Y: origin_y <= cfg_data;
      endcase
    end
  end

  // Advance a stage when it is empty or the next one advances
  assign en[TOT-1] = !vld[TOT-1] || rsp.ready;
  for (genvar i = 0; i < TOT-1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= req.valid;
      end
      for (int i = 1; i < TOT; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign req.ready = en[0];
  assign rsp.valid = vld[TOT-1];

  cpc_front u_front (
    .clk      (clk),
    .en       (en[2:0]),
    .kind     (req.kind),
    .point_x  (req.point_x),
    .point_y  (req.point_y),
    .radius   (req.radius),
    .angle_in (req.angle_in),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .init     (data[0])
  );

  // Core chain: each stage does a micro-rotation while idx < CORDIC_N and a root bit while idx < SQRT_BITS
  for (genvar i = 0; i < K; i++) begin : g_core
    cpc_stage u_stage (
      .clk (clk),
      .idx (5'(i)),
      .en  (en[3+i]),
      .d   (data[i]),
      .q   (data[i+1])
    );
  end

  cpc_finish u_finish (
    .clk             (clk),
    .en              (en[TOT-1]),
    .d               (data[K]),
    .signed_distance (rsp.signed_distance),
    .angle_out       (rsp.angle_out),
    .region          (rsp.region),
    .rect_x          (rsp.rect_x),
    .rect_y          (rsp.rect_y)
  );

endmodule

// ===== rtl/core/cpc_checker.sv =====
// Port-level checks on the converter's response channel.
`timescale 1ns / 1ps
module cpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [17:0] signed_distance,
  input logic [15:0] angle_out,
  input logic [3:0]  region,
  input logic [16:0] rect_x,
  input logic [16:0] rect_y
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_polar_rect_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && region != cpc_pkg::REGION_ORIGIN |-> rect_x == '0 && rect_y == '0)
    else $error("vectoring response with rect fields set");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && region == cpc_pkg::REGION_ORIGIN && (rect_x != '0 || rect_y != '0)
    |-> signed_distance == '0 && angle_out == '0)
    else $error("rotation response with polar fields set");

  a_axis_positive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (region == cpc_pkg::REGION_POS_X || region == cpc_pkg::REGION_POS_Y ||
                  region == cpc_pkg::REGION_NEG_X || region == cpc_pkg::REGION_NEG_Y)
    |-> !signed_distance[17])
    else $error("negative distance on an axis");

endmodule

bind cartesian_polar_converter_unit cpc_checker u_cpc_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .signed_distance (rsp.signed_distance),
  .angle_out       (rsp.angle_out),
  .region          (rsp.region),
  .rect_x          (rsp.rect_x),
  .rect_y          (rsp.rect_y)
);
